>>> rtl/rsd_pkg.sv
// Shared types and constants for the record stream deframer.
// Depends on nothing; imported by every module in rtl/.
package rsd_pkg;

    // Result status codes
    localparam logic [1:0] STAT_RECORD  = 2'd0;
    localparam logic [1:0] STAT_CORRUPT = 2'd1;
    localparam logic [1:0] STAT_END     = 2'd2;

    // Value kinds
    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_HALF  = 2'd1;
    localparam logic [1:0] KIND_WORD  = 2'd2;
    localparam logic [1:0] KIND_FIXED = 2'd3;

    // Type byte codes on the wire
    localparam logic [7:0] TYPE_BYTE  = 8'h01;
    localparam logic [7:0] TYPE_HALF  = 8'h02;
    localparam logic [7:0] TYPE_WORD  = 8'h04;
    localparam logic [7:0] TYPE_FIXED = 8'hFF;

    // Parse positions: 1..3 next length byte, REC_BASE + r is record byte r
    localparam logic [4:0] POS_IDLE     = 5'd0;
    localparam logic [4:0] POS_LEN1     = 5'd1;
    localparam logic [4:0] REC_BASE     = 5'd4;
    localparam logic [4:0] OFF_MAJOR    = 5'd0;
    localparam logic [4:0] OFF_MINOR    = 5'd1;
    localparam logic [4:0] OFF_ID_FIRST = 5'd2;
    localparam logic [4:0] OFF_ID_LAST  = 5'd5;
    localparam logic [4:0] OFF_SEC_FIRST = 5'd6;
    localparam logic [4:0] OFF_SEC_LAST = 5'd9;
    localparam logic [4:0] OFF_MS_FIRST = 5'd10;
    localparam logic [4:0] OFF_MS_LAST  = 5'd11;
    localparam logic [4:0] OFF_TYPE     = 5'd12;
    localparam logic [4:0] OFF_VALUE    = 5'd13;

    // Within a fixed-point value, bytes from this index on are thousandths
    localparam logic [2:0] FIXED_MS_FIRST = 3'd4;

    // One result item
    typedef struct packed {
        logic [15:0] value_millis;
        logic [31:0] value_word;
        logic [1:0]  value_kind;
        logic [15:0] time_millis;
        logic [31:0] time_seconds;
        logic [31:0] record_id;
        logic [7:0]  minor_code;
        logic [7:0]  major_code;
        logic [1:0]  status;
    } rsd_result_t;

    // Index of the last value byte for a kind
    function automatic logic [2:0] last_value_index(input logic [1:0] kind);
        logic [2:0] idx;
        case (kind)
            KIND_BYTE: idx = 3'd0;
            KIND_HALF: idx = 3'd1;
            KIND_WORD: idx = 3'd3;
            default:   idx = 3'd5;
        endcase
        return idx;
    endfunction

endpackage

>>> rtl/record_stream_deframer.sv
// Top level of the record stream deframer: parser plus result buffer.
// Depends on rsd_pkg, rsd_parser and rsd_out_buf.
//
//  Channel  | Direction | tdata                          | tuser
//  ---------+-----------+--------------------------------+-------------------------
//  s_axis   | in        | data_byte[7:0]                 | stream_start[0]
//  m_axis   | out       | major..value_millis (144 bits) | status[1:0], kind[3:2]
//
//  One input byte is taken per cycle while input ready is high; a result
//  appears in the buffer in the cycle after the byte that completes it. The
//  two-entry result buffer sets input ready, so the input pauses only while
//  two results wait downstream. rst_n clears the buffer and puts the parser
//  in its stopped state: bytes are dropped until one arrives with stream_start set.
module record_stream_deframer
    import rsd_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [7:0]    s_axis_tdata,   // data_byte[7:0]
    input  logic          s_axis_tuser,   // stream_start
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [143:0]  m_axis_tdata,   // major[7:0], minor[15:8], record_id[47:16],
                                          // time_seconds[79:48], time_millis[95:80],
                                          // value_word[127:96], value_millis[143:128]
    output logic [3:0]    m_axis_tuser    // status[1:0], value_kind[3:2]
);

    logic        byte_take;
    logic        res_valid;
    logic        has_room;
    rsd_result_t res;
    rsd_result_t out_res;

    assign s_axis_tready = has_room;
    assign byte_take     = s_axis_tvalid && has_room;

    rsd_parser u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_take    (byte_take),
        .data_byte    (s_axis_tdata),
        .stream_start (s_axis_tuser),
        .res_valid    (res_valid),
        .res          (res)
    );

    rsd_out_buf u_out_buf (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (res_valid),
        .wr_data  (res),
        .has_room (has_room),
        .rd_valid (m_axis_tvalid),
        .rd_ready (m_axis_tready),
        .rd_data  (out_res)
    );

    // Pack the result onto the output transfer
    assign m_axis_tdata = {out_res.value_millis, out_res.value_word,
                           out_res.time_millis, out_res.time_seconds,
                           out_res.record_id, out_res.minor_code,
                           out_res.major_code};
    assign m_axis_tuser = {out_res.value_kind, out_res.status};

endmodule

>>> rtl/rsd_parser.sv
// Byte parser: length header, record fields and value, one byte per cycle while byte_take is high.
// Depends on rsd_pkg.
module rsd_parser
    import rsd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_take,     // a byte transfer happens this cycle
    input  logic [7:0]  data_byte,
    input  logic        stream_start,
    output logic        res_valid,
    output rsd_result_t res
);

    logic        stopped_reg, stopped_next;
    logic [4:0]  pos_reg, pos_next;
    logic [31:0] len_reg, len_next;
    logic [31:0] cons_reg, cons_next;
    logic [7:0]  major_reg, major_next;
    logic [7:0]  minor_reg, minor_next;
    logic [31:0] id_reg, id_next;
    logic [31:0] sec_reg, sec_next;
    logic [15:0] ms_reg, ms_next;
    logic [1:0]  kind_reg, kind_next;
    logic [31:0] value_reg, value_next;
    logic [15:0] vms_reg, vms_next;

    logic [4:0]  rec_off;
    logic [4:0]  val_off_full;
    logic [2:0]  val_off;

    assign rec_off      = pos_reg - REC_BASE;
    assign val_off_full = rec_off - OFF_VALUE;
    assign val_off      = val_off_full[2:0];

    // Next-state and result logic for one byte
    always_comb
    begin
        stopped_next = stopped_reg;
        pos_next     = pos_reg;
        len_next     = len_reg;
        cons_next    = cons_reg;
        major_next   = major_reg;
        minor_next   = minor_reg;
        id_next      = id_reg;
        sec_next     = sec_reg;
        ms_next      = ms_reg;
        kind_next    = kind_reg;
        value_next   = value_reg;
        vms_next     = vms_reg;
        res_valid    = 1'b0;
        res          = '0;

        if (byte_take)
        begin
            if (stream_start)
            begin
                // restart, even mid-record
                stopped_next = 1'b0;
                len_next     = {data_byte, 24'd0};
                cons_next    = '0;
                pos_next     = POS_LEN1;
            end
            else if (!stopped_reg)
            begin
                if (pos_reg < REC_BASE)
                begin
                    len_next = {len_reg[23:0], data_byte};
                    pos_next = pos_reg + 5'd1;
                end
                else if (rec_off == OFF_MAJOR && cons_reg >= len_reg)
                begin
                    // length used up at a record start
                    stopped_next = 1'b1;
                    pos_next     = POS_IDLE;
                    res_valid    = 1'b1;
                    res.status   = STAT_END;
                end
                else
                begin
                    if (cons_reg != 32'hFFFF_FFFF)
                        cons_next = cons_reg + 32'd1;
                    pos_next = pos_reg + 5'd1;

                    case (rec_off) inside
                        OFF_MAJOR: major_next = data_byte;
                        OFF_MINOR: minor_next = data_byte;
                        [OFF_ID_FIRST:OFF_ID_LAST]:
                            id_next = {id_reg[23:0], data_byte};
                        [OFF_SEC_FIRST:OFF_SEC_LAST]:
                            sec_next = {sec_reg[23:0], data_byte};
                        [OFF_MS_FIRST:OFF_MS_LAST]:
                            ms_next = {ms_reg[7:0], data_byte};
                        OFF_TYPE:
                        begin
                            value_next = '0;
                            vms_next   = '0;
                            case (data_byte)
                                TYPE_BYTE:  kind_next = KIND_BYTE;
                                TYPE_HALF:  kind_next = KIND_HALF;
                                TYPE_WORD:  kind_next = KIND_WORD;
                                TYPE_FIXED: kind_next = KIND_FIXED;
                                default:
                                begin
                                    // bad type: report header, then stop
                                    kind_next        = KIND_BYTE;
                                    stopped_next     = 1'b1;
                                    pos_next         = POS_IDLE;
                                    res_valid        = 1'b1;
                                    res.status       = STAT_CORRUPT;
                                    res.major_code   = major_reg;
                                    res.minor_code   = minor_reg;
                                    res.record_id    = id_reg;
                                    res.time_seconds = sec_reg;
                                    res.time_millis  = ms_reg;
                                end
                            endcase
                        end
                        default:
                        begin
                            // value bytes
                            if (kind_reg == KIND_FIXED && val_off >= FIXED_MS_FIRST)
                                vms_next = {vms_reg[7:0], data_byte};
                            else
                                value_next = {value_reg[23:0], data_byte};
                            if (val_off >= last_value_index(kind_reg))
                            begin
                                pos_next         = REC_BASE;
                                res_valid        = 1'b1;
                                res.status       = STAT_RECORD;
                                res.major_code   = major_reg;
                                res.minor_code   = minor_reg;
                                res.record_id    = id_reg;
                                res.time_seconds = sec_reg;
                                res.time_millis  = ms_reg;
                                res.value_kind   = kind_reg;
                                res.value_word   = value_next;
                                res.value_millis = vms_next;
                            end
                        end
                    endcase
                end
            end
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stopped_reg <= 1'b1;
            pos_reg     <= POS_IDLE;
            len_reg     <= '0;
            cons_reg    <= '0;
            major_reg   <= '0;
            minor_reg   <= '0;
            id_reg      <= '0;
            sec_reg     <= '0;
            ms_reg      <= '0;
            kind_reg    <= KIND_BYTE;
            value_reg   <= '0;
            vms_reg     <= '0;
        end
        else
        begin
            stopped_reg <= stopped_next;
            pos_reg     <= pos_next;
            len_reg     <= len_next;
            cons_reg    <= cons_next;
            major_reg   <= major_next;
            minor_reg   <= minor_next;
            id_reg      <= id_next;
            sec_reg     <= sec_next;
            ms_reg      <= ms_next;
            kind_reg    <= kind_next;
            value_reg   <= value_next;
            vms_reg     <= vms_next;
        end
    end

endmodule

>>> rtl/rsd_out_buf.sv
// Two-entry result buffer; its ready depends only on its own fill level.
// Depends on rsd_pkg.
module rsd_out_buf
    import rsd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        wr_valid,
    input  rsd_result_t wr_data,
    output logic        has_room,
    output logic        rd_valid,
    input  logic        rd_ready,
    output rsd_result_t rd_data
);

    rsd_result_t mem_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        push, pop;

    assign has_room = (count_reg != 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign push     = wr_valid;
    assign pop      = rd_valid && rd_ready;

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Result storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for record_stream_deframer: directed table, then random record files.
// Depends on rsd_pkg and the RTL under rtl/; results are checked against a local predictor.
module tb;
    import rsd_pkg::*;

    localparam int RANDOM_BYTES = 1000;
    localparam int STEADY_FROM  = 900;
    localparam int PAUSE_AT     = 500;
    localparam int HOLD_CYCLES  = 80;
    localparam int DRAIN_CYCLES = 16;
    localparam int IDLE_LIMIT   = 2000;

    logic         clk;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata = 8'h00;   // data_byte[7:0]
    logic         s_axis_tuser = 1'b0;    // stream_start
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [143:0] m_axis_tdata;           // major, minor, record_id, time_seconds,
                                          // time_millis, value_word, value_millis
    logic [3:0]   m_axis_tuser;           // status[1:0], value_kind[3:2]

    record_stream_deframer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Directed stimulus row; typed rows carry the result they must produce
    typedef struct packed {
        logic [7:0]  data;
        logic        start;
        logic        typed;
        rsd_result_t result;
    } dir_row_t;

    localparam rsd_result_t NO_RESULT   = '0;
    localparam rsd_result_t END_SEEN    = '{status: STAT_END, default: '0};
    localparam rsd_result_t CORRUPT_SEEN = '{status: STAT_CORRUPT, major_code: 8'hFF,
                                             minor_code: 8'h00, record_id: 32'hFFFF_FFFF,
                                             time_seconds: 32'h0, time_millis: 16'hFFFF,
                                             default: '0};

    dir_row_t dir_table [24] = '{
        '{8'hFF, 1'b0, 1'b0, NO_RESULT},     // stopped after reset: dropped
        '{8'h00, 1'b1, 1'b0, NO_RESULT},     // zero length file
        '{8'h00, 1'b0, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, 1'b0, NO_RESULT},
        '{8'hAB, 1'b0, 1'b1, END_SEEN},      // record start with length used up
        '{8'h55, 1'b0, 1'b0, NO_RESULT},     // stopped again: dropped
        '{8'h00, 1'b1, 1'b0, NO_RESULT},     // length 14
        '{8'h00, 1'b0, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, 1'b0, NO_RESULT},
        '{8'h0E, 1'b0, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, 1'b0, NO_RESULT},     // major
        '{8'h00, 1'b0, 1'b0, NO_RESULT},     // minor
        '{8'hFF, 1'b0, 1'b0, NO_RESULT},     // id
        '{8'hFF, 1'b0, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, 1'b0, NO_RESULT},     // seconds
        '{8'h00, 1'b0, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, 1'b0, NO_RESULT},     // millis
        '{8'hFF, 1'b0, 1'b0, NO_RESULT},
        '{8'h03, 1'b0, 1'b1, CORRUPT_SEEN}   // bad type byte
    };

    // Predictor state
    logic [31:0] exp_length;
    logic [31:0] exp_consumed;
    logic [4:0]  exp_pos;
    logic [7:0]  exp_major;
    logic [7:0]  exp_minor;
    logic [31:0] exp_id;
    logic [31:0] exp_seconds;
    logic [15:0] exp_millis;
    logic [1:0]  exp_kind;
    logic [31:0] exp_value;
    logic [15:0] exp_value_ms;
    logic        exp_stopped;

    rsd_result_t pending_results [$];
    logic [8:0]  file_bytes [$];         // {stream_start, data_byte}
    int          mismatch_count = 0;
    int          results_seen = 0;
    int          bytes_used = 0;
    bit          steady_phase = 1'b0;
    bit          long_hold_done = 1'b0;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Reset, once
    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Predict the effect of one accepted byte
    task automatic deframe_byte(input logic [7:0] b, input logic st, output bit produced,
                                output bit used, output rsd_result_t res);
        logic [4:0] off;
        logic [4:0] vpos;
        logic [2:0] vidx;
        logic [2:0] last_idx;
        produced = 1'b0;
        used = st || !exp_stopped;
        res = '0;
        if (st)
        begin
            exp_stopped = 1'b0;
            exp_length = {b, 24'h0};
            exp_consumed = '0;
            exp_pos = POS_LEN1;
        end
        else if (exp_stopped)
        begin
            // dropped until the next stream start
        end
        else if (exp_pos < REC_BASE)
        begin
            exp_length = {exp_length[23:0], b};
            exp_pos = exp_pos + 5'd1;
        end
        else
        begin
            off = exp_pos - REC_BASE;
            if (off == OFF_MAJOR && exp_consumed >= exp_length)
            begin
                exp_stopped = 1'b1;
                exp_pos = POS_IDLE;
                produced = 1'b1;
                res.status = STAT_END;
            end
            else
            begin
                if (exp_consumed != 32'hFFFF_FFFF)
                    exp_consumed = exp_consumed + 32'd1;
                exp_pos = exp_pos + 5'd1;
                if (off == OFF_MAJOR)
                    exp_major = b;
                else if (off == OFF_MINOR)
                    exp_minor = b;
                else if (off <= OFF_ID_LAST)
                    exp_id = {exp_id[23:0], b};
                else if (off <= OFF_SEC_LAST)
                    exp_seconds = {exp_seconds[23:0], b};
                else if (off <= OFF_MS_LAST)
                    exp_millis = {exp_millis[7:0], b};
                else if (off == OFF_TYPE)
                begin
                    exp_value = '0;
                    exp_value_ms = '0;
                    case (b)
                        TYPE_BYTE:  exp_kind = KIND_BYTE;
                        TYPE_HALF:  exp_kind = KIND_HALF;
                        TYPE_WORD:  exp_kind = KIND_WORD;
                        TYPE_FIXED: exp_kind = KIND_FIXED;
                        default:
                        begin
                            exp_kind = KIND_BYTE;
                            exp_stopped = 1'b1;
                            exp_pos = POS_IDLE;
                            produced = 1'b1;
                            res.status = STAT_CORRUPT;
                        end
                    endcase
                end
                else
                begin
                    vpos = off - OFF_VALUE;
                    vidx = vpos[2:0];
                    if (exp_kind == KIND_FIXED && vidx >= FIXED_MS_FIRST)
                        exp_value_ms = {exp_value_ms[7:0], b};
                    else
                        exp_value = {exp_value[23:0], b};
                    case (exp_kind)
                        KIND_BYTE: last_idx = 3'd0;
                        KIND_HALF: last_idx = 3'd1;
                        KIND_WORD: last_idx = 3'd3;
                        default:   last_idx = 3'd5;
                    endcase
                    if (vidx == last_idx)
                    begin
                        exp_pos = REC_BASE;
                        produced = 1'b1;
                        res.status = STAT_RECORD;
                    end
                end
            end
        end
        // Header fields go out on record and corrupt results, value only on records
        if (produced && res.status != STAT_END)
        begin
            res.major_code   = exp_major;
            res.minor_code   = exp_minor;
            res.record_id    = exp_id;
            res.time_seconds = exp_seconds;
            res.time_millis  = exp_millis;
        end
        if (produced && res.status == STAT_RECORD)
        begin
            res.value_kind   = exp_kind;
            res.value_word   = exp_value;
            res.value_millis = exp_value_ms;
        end
    endtask

    // Offer one byte, with an optional idle burst first; returns after the transfer
    task automatic offer_byte(input logic [7:0] d, input logic st);
        int gap;
        if (!steady_phase && $urandom_range(0, 5) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            gap = $urandom_range(1, 3);
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        s_axis_tuser  <= st;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    // Build one random file: header, records, and sometimes trailing or cut bytes
    task automatic build_file();
        logic [7:0]  body [$];
        logic [7:0]  tbyte;
        logic [31:0] len;
        int          nrec;
        int          nval;
        int          mode;
        int          cut;
        int          k;
        bit          broke;
        body = {};
        broke = 1'b0;
        nrec = $urandom_range(1, 4);
        for (k = 0; k < nrec && !broke; k++)
        begin
            repeat (12) body.push_back(8'($urandom_range(0, 255)));
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4:     tbyte = TYPE_BYTE;
                5, 6, 7, 8, 9:     tbyte = TYPE_HALF;
                10, 11, 12, 13, 14: tbyte = TYPE_WORD;
                15, 16, 17, 18:    tbyte = TYPE_FIXED;
                default:           tbyte = 8'($urandom_range(0, 255));
            endcase
            body.push_back(tbyte);
            case (tbyte)
                TYPE_BYTE:  nval = 1;
                TYPE_HALF:  nval = 2;
                TYPE_WORD:  nval = 4;
                TYPE_FIXED: nval = 6;
                default:
                begin
                    nval = 0;
                    broke = 1'b1;
                end
            endcase
            repeat (nval) body.push_back(8'($urandom_range(0, 255)));
        end
        mode = $urandom_range(0, 9);
        case (mode)
            6:       len = body.size() - $urandom_range(1, 5);    // last record runs past length
            7:       len = $urandom();                            // ended only by a new start
            8:       len = body.size() + $urandom_range(1, 20);
            9:
            begin
                // cut short: the next start lands mid-record
                len = body.size();
                cut = $urandom_range(1, body.size() - 1);
                body = body[0:cut-1];
            end
            default: len = body.size();
        endcase
        file_bytes.push_back({1'b1, len[31:24]});
        file_bytes.push_back({1'b0, len[23:16]});
        file_bytes.push_back({1'b0, len[15:8]});
        file_bytes.push_back({1'b0, len[7:0]});
        foreach (body[i])
            file_bytes.push_back({1'b0, body[i]});
        if (mode <= 6)
            repeat ($urandom_range(1, 3)) file_bytes.push_back({1'b0, 8'($urandom_range(0, 255))});
    endtask

    // Sender: directed table, random files, then drain
    initial
    begin
        bit          produced;
        bit          used;
        bit          paused;
        rsd_result_t res;
        logic [8:0]  item;
        exp_length = '0;
        exp_consumed = '0;
        exp_pos = POS_IDLE;
        exp_major = '0;
        exp_minor = '0;
        exp_id = '0;
        exp_seconds = '0;
        exp_millis = '0;
        exp_kind = KIND_BYTE;
        exp_value = '0;
        exp_value_ms = '0;
        exp_stopped = 1'b1;
        paused = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);

        // Directed rows
        foreach (dir_table[i])
        begin
            offer_byte(dir_table[i].data, dir_table[i].start);
            deframe_byte(dir_table[i].data, dir_table[i].start, produced, used, res);
            if (dir_table[i].typed)
                pending_results.push_back(dir_table[i].result);
            else if (produced)
                pending_results.push_back(res);
        end

        // Random files
        while (bytes_used < RANDOM_BYTES)
        begin
            if (!paused && bytes_used >= PAUSE_AT)
            begin
                paused = 1'b1;
                s_axis_tvalid <= 1'b0;
                do
                    @(posedge clk);
                while (pending_results.size() != 0);
            end
            build_file();
            while (file_bytes.size() != 0)
            begin
                item = file_bytes.pop_front();
                offer_byte(item[7:0], item[8]);
                deframe_byte(item[7:0], item[8], produced, used, res);
                if (produced)
                    pending_results.push_back(res);
                if (used)
                    bytes_used++;
                if (bytes_used >= STEADY_FROM)
                    steady_phase = 1'b1;
            end
        end
        s_axis_tvalid <= 1'b0;

        // Drain
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Receiver ready: short random stalls, one long hold-off, none at the end
    initial
    begin
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
                stall_left--;
            else if (!long_hold_done && results_seen >= 4)
            begin
                long_hold_done = 1'b1;
                stall_left = HOLD_CYCLES;
            end
            else if (!steady_phase && $urandom_range(0, 4) == 0)
                stall_left = $urandom_range(1, 3);
            m_axis_tready <= rst_n && (stall_left == 0);
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] seen);
        if (want !== seen)
        begin
            mismatch_count++;
            $display("[%0t] %s mismatch: expected %h, actual %h", $time, name, want, seen);
        end
    endtask

    // Result checker
    always @(posedge clk)
    begin
        rsd_result_t seen;
        rsd_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            results_seen++;
            seen.status       = m_axis_tuser[1:0];
            seen.value_kind   = m_axis_tuser[3:2];
            seen.major_code   = m_axis_tdata[7:0];
            seen.minor_code   = m_axis_tdata[15:8];
            seen.record_id    = m_axis_tdata[47:16];
            seen.time_seconds = m_axis_tdata[79:48];
            seen.time_millis  = m_axis_tdata[95:80];
            seen.value_word   = m_axis_tdata[127:96];
            seen.value_millis = m_axis_tdata[143:128];
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                $display("[%0t] unexpected result: expected none, actual status %0d",
                         $time, seen.status);
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("status", 32'(want.status), 32'(seen.status));
                check_field("major_code", 32'(want.major_code), 32'(seen.major_code));
                check_field("minor_code", 32'(want.minor_code), 32'(seen.minor_code));
                check_field("record_id", want.record_id, seen.record_id);
                check_field("time_seconds", want.time_seconds, seen.time_seconds);
                check_field("time_millis", 32'(want.time_millis), 32'(seen.time_millis));
                check_field("value_kind", 32'(want.value_kind), 32'(seen.value_kind));
                check_field("value_word", want.value_word, seen.value_word);
                check_field("value_millis", 32'(want.value_millis), 32'(seen.value_millis));
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        int idle_cycles;
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

endmodule

>>> record_stream_deframer.f
rtl/rsd_pkg.sv
rtl/rsd_parser.sv
rtl/rsd_out_buf.sv
rtl/record_stream_deframer.sv
bench/tb.sv
